@@ design/r16d_pkg.sv @@
package r16d_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned OP_W   = 6;
  localparam int unsigned MASK_W = 42;

  localparam logic [MASK_W-1:0] MASK_RESET = 42'h0C17FFB30C7;

  // opcode numbers follow the capability bit order
  localparam logic [OP_W-1:0] OP_MOV      = 6'd0;
  localparam logic [OP_W-1:0] OP_ALU1_B   = 6'd3;
  localparam logic [OP_W-1:0] OP_AND      = 6'd6;
  localparam logic [OP_W-1:0] OP_OR       = 6'd7;
  localparam logic [OP_W-1:0] OP_ALU3_B   = 6'd8;
  localparam logic [OP_W-1:0] OP_SHL      = 6'd12;
  localparam logic [OP_W-1:0] OP_SHR      = 6'd13;
  localparam logic [OP_W-1:0] OP_BSH      = 6'd14;
  localparam logic [OP_W-1:0] OP_ABSH     = 6'd15;
  localparam logic [OP_W-1:0] OP_XCH      = 6'd16;
  localparam logic [OP_W-1:0] OP_TST      = 6'd17;
  localparam logic [OP_W-1:0] OP_CMP      = 6'd18;
  localparam logic [OP_W-1:0] OP_JC       = 6'd32;
  localparam logic [OP_W-1:0] OP_JRELC    = 6'd33;
  localparam logic [OP_W-1:0] OP_JEC      = 6'd34;
  localparam logic [OP_W-1:0] OP_JAC      = 6'd36;
  localparam logic [OP_W-1:0] OP_IO_B     = 6'd38;
  localparam logic [OP_W-1:0] OP_LAST     = 6'd41;

  // immediate-form opcodes by bits 14..12, register-addressed memory by bits 11..9
  localparam logic [OP_W-1:0] IMM_OPS [0:6] = '{
    6'd19, 6'd20, 6'd22, 6'd24, 6'd26, 6'd28, 6'd30
  };
  localparam logic [OP_W-1:0] MEM_OPS [0:5] = '{
    6'd21, 6'd23, 6'd25, 6'd27, 6'd29, 6'd31
  };

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic              undefined_encoding;
    logic              permitted;
    logic [2:0]        reg_first;
    logic [2:0]        reg_second;
    logic [2:0]        reg_third;
    logic [3:0]        shift_count;
    logic [8:0]        imm_or_address;
    logic [3:0]        cond_or_mask;
    logic signed [7:0] jump_offset;
    logic [4:0]        jump_base;
    logic [2:0]        port_number;
  } dec_t;

endpackage

@@ design/r16d_mask_reg.sv @@
module r16d_mask_reg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [r16d_pkg::MASK_W-1:0]    wr_data,
  output logic [r16d_pkg::MASK_W-1:0]    mask
);

  logic [r16d_pkg::MASK_W-1:0] mask_r;
  logic [r16d_pkg::MASK_W-1:0] mask_nxt;

  always_comb begin
    mask_nxt = mask_r;
    if (wr_en) begin
      mask_nxt = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= r16d_pkg::MASK_RESET;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  assign mask = mask_r;

endmodule

@@ design/r16d_decode.sv @@
module r16d_decode (
  input  logic [r16d_pkg::WORD_W-1:0] word,
  input  logic [r16d_pkg::MASK_W-1:0] mask,
  output r16d_pkg::dec_t              dec
);

  logic [63:0]                 mask_ext;
  logic                        defined;
  logic [r16d_pkg::OP_W-1:0]   op;
  logic [1:0]                  sel;
  logic [1:0]                  lo;
  r16d_pkg::dec_t              f;

  assign mask_ext = {{(64 - r16d_pkg::MASK_W){1'b0}}, mask};
  assign sel      = word[12:11];
  assign lo       = word[1:0];

  always_comb begin
    f       = '0;
    op      = r16d_pkg::OP_MOV;
    defined = 1'b1;
    if (word[15]) begin
      // immediate and memory class
      if (word[14:12] != 3'd7) begin
        op               = r16d_pkg::IMM_OPS[word[14:12]];
        f.reg_first      = word[11:9];
        f.imm_or_address = word[8:0];
      end else if (word[11:9] > 3'd5) begin
        defined = 1'b0;
      end else begin
        op           = r16d_pkg::MEM_OPS[word[11:9]];
        f.reg_first  = word[7:5];
        f.reg_second = word[4:2];
      end
    end else if (word[14]) begin
      // jumps and port i/o
      if (word[13]) begin
        op            = r16d_pkg::OP_IO_B + {4'd0, sel};
        f.reg_first   = word[10:8];
        f.port_number = word[7:5];
      end else if (sel == 2'd0) begin
        op            = r16d_pkg::OP_JC;
        f.cond_or_mask = {1'b0, word[10:8]};
        f.jump_offset = word[7:0];
      end else if (sel == 2'd1) begin
        op             = r16d_pkg::OP_JRELC;
        f.cond_or_mask = {1'b0, word[10:8]};
        f.reg_second   = word[7:5];
        f.jump_base    = word[4:0];
      end else begin
        op = ((sel == 2'd2) ? r16d_pkg::OP_JEC : r16d_pkg::OP_JAC)
             + {5'd0, ~word[6]};
        f.cond_or_mask = word[10:7];
        f.jump_offset  = {{2{word[5]}}, word[5:0]};
      end
    end else begin
      // register operations, group in bits 13..11
      case (word[13:11])
        3'd0: begin
          if (lo == 2'd3) begin
            defined = 1'b0;
          end else begin
            op           = r16d_pkg::OP_MOV + {4'd0, lo};
            f.reg_first  = word[10:8];
            f.reg_second = word[7:5];
            if (lo != 2'd0) begin
              f.reg_third = word[4:2];
            end
          end
        end
        3'd1: begin
          if (lo == 2'd3) begin
            defined = 1'b0;
          end else begin
            op           = r16d_pkg::OP_ALU1_B + {4'd0, lo};
            f.reg_first  = word[10:8];
            f.reg_second = word[7:5];
            f.reg_third  = word[4:2];
          end
        end
        3'd2: begin
          op           = word[0] ? r16d_pkg::OP_OR : r16d_pkg::OP_AND;
          f.reg_first  = word[10:8];
          f.reg_second = word[7:5];
          f.reg_third  = word[4:2];
        end
        3'd3: begin
          op           = r16d_pkg::OP_ALU3_B + {4'd0, lo};
          f.reg_first  = word[10:8];
          f.reg_second = word[7:5];
          f.reg_third  = word[4:2];
        end
        3'd4: begin
          op            = word[4] ? r16d_pkg::OP_SHR : r16d_pkg::OP_SHL;
          f.reg_first   = word[10:8];
          f.reg_second  = word[7:5];
          f.shift_count = word[3:0];
        end
        3'd5: begin
          op            = word[0] ? r16d_pkg::OP_ABSH : r16d_pkg::OP_BSH;
          f.reg_first   = word[10:8];
          f.reg_second  = word[7:5];
          f.shift_count = {1'b0, word[4:2]};
        end
        3'd6: begin
          op           = r16d_pkg::OP_XCH;
          f.reg_first  = word[7:5];
          f.reg_second = word[4:2];
        end
        default: begin
          f.reg_first = word[7:5];
          if (word[0]) begin
            op           = r16d_pkg::OP_CMP;
            f.reg_second = word[4:2];
          end else begin
            op = r16d_pkg::OP_TST;
          end
        end
      endcase
    end

    if (defined) begin
      dec           = f;
      dec.opcode    = op;
      dec.permitted = mask_ext[op];
    end else begin
      dec                    = '0;
      dec.undefined_encoding = 1'b1;
    end
  end

endmodule

@@ design/risc16_instruction_decoder_unit.sv @@
// 16-bit instruction decoder: takes one instruction word per item and returns one decoded
// item carrying the opcode (numbered in capability bit order, 0 to 41), the operand fields
// cut out for that form, an undefined-encoding flag and a permitted flag taken from the
// 42-bit opcode enable mask. The accepting edge loads the word into the input register,
// the decode logic sits between the two registers and the result register takes the decoded
// item once it has room; out_valid rises when the result register is loaded.
// Throughput is one item per cycle while out_ready stays high; both stages are elastic, so
// a stall on the output side fills the two registers before in_ready drops. The enable mask
// resets to the base instruction set and is rewritten through the cfg channel, which is
// always ready; write it only while no item is in flight. Fields a form does not use read
// as zero, and an undefined word yields opcode 0 with every operand field zero.
module risc16_instruction_decoder_unit (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [r16d_pkg::WORD_W-1:0]       in_instruction_word,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [r16d_pkg::OP_W-1:0]         out_opcode,
  output logic                              out_undefined_encoding,
  output logic                              out_permitted,
  output logic [2:0]                        out_reg_first,
  output logic [2:0]                        out_reg_second,
  output logic [2:0]                        out_reg_third,
  output logic [3:0]                        out_shift_count,
  output logic [8:0]                        out_imm_or_address,
  output logic [3:0]                        out_cond_or_mask,
  output logic signed [7:0]                 out_jump_offset,
  output logic [4:0]                        out_jump_base,
  output logic [2:0]                        out_port_number,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [r16d_pkg::MASK_W-1:0]       cfg_opcode_enable_mask
);

  // input stage
  logic                          in_vld_r;
  logic                          in_vld_nxt;
  logic [r16d_pkg::WORD_W-1:0]   word_r;
  logic [r16d_pkg::WORD_W-1:0]   word_nxt;

  // result stage
  logic                          out_vld_r;
  logic                          out_vld_nxt;
  r16d_pkg::dec_t                res_r;
  r16d_pkg::dec_t                res_nxt;

  logic                          res_ready;
  logic [r16d_pkg::MASK_W-1:0]   mask;
  r16d_pkg::dec_t                dec;

  // configuration is a plain register write, never back-pressured
  assign cfg_ready = 1'b1;

  r16d_mask_reg u_mask (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_data (cfg_opcode_enable_mask),
    .mask    (mask)
  );

  r16d_decode u_decode (
    .word (word_r),
    .mask (mask),
    .dec  (dec)
  );

  // each stage moves on when the stage after it is empty or draining
  assign res_ready = !out_vld_r || out_ready;
  assign in_ready  = !in_vld_r || res_ready;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    word_nxt    = word_r;
    out_vld_nxt = out_vld_r;
    res_nxt     = res_r;
    if (in_ready) begin
      in_vld_nxt = in_valid;
      if (in_valid) begin
        word_nxt = in_instruction_word;
      end
    end
    if (res_ready) begin
      out_vld_nxt = in_vld_r;
      if (in_vld_r) begin
        res_nxt = dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid              = out_vld_r;
  assign out_opcode             = res_r.opcode;
  assign out_undefined_encoding = res_r.undefined_encoding;
  assign out_permitted          = res_r.permitted;
  assign out_reg_first          = res_r.reg_first;
  assign out_reg_second         = res_r.reg_second;
  assign out_reg_third          = res_r.reg_third;
  assign out_shift_count        = res_r.shift_count;
  assign out_imm_or_address     = res_r.imm_or_address;
  assign out_cond_or_mask       = res_r.cond_or_mask;
  assign out_jump_offset        = res_r.jump_offset;
  assign out_jump_base          = res_r.jump_base;
  assign out_port_number        = res_r.port_number;

endmodule

@@ design/r16d_checker.sv @@
module r16d_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [r16d_pkg::OP_W-1:0]    out_opcode,
  input logic                         out_undefined_encoding,
  input logic                         out_permitted,
  input logic [2:0]                   out_reg_first,
  input logic [2:0]                   out_reg_second,
  input logic [2:0]                   out_reg_third,
  input logic [3:0]                   out_shift_count,
  input logic [8:0]                   out_imm_or_address,
  input logic [3:0]                   out_cond_or_mask,
  input logic signed [7:0]            out_jump_offset,
  input logic [4:0]                   out_jump_base,
  input logic [2:0]                   out_port_number
);

  // a stalled result item keeps its valid, opcode, immediate and jump offset
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_opcode)
      && $stable(out_imm_or_address) && $stable(out_jump_offset))
    else $error("result item changed while stalled");

  a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_opcode <= r16d_pkg::OP_LAST)
    else $error("opcode out of range");

  a_undef_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_undefined_encoding |-> out_opcode == '0 && !out_permitted
      && out_reg_first == '0 && out_reg_second == '0 && out_reg_third == '0
      && out_shift_count == '0 && out_imm_or_address == '0 && out_cond_or_mask == '0
      && out_jump_offset == '0 && out_jump_base == '0 && out_port_number == '0)
    else $error("undefined item carries operand data");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind risc16_instruction_decoder_unit r16d_checker u_r16d_checker (.*);

@@ bench/r16d_decode_checker.sv @@
module r16d_decode_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [r16d_pkg::WORD_W-1:0] in_instruction_word,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [r16d_pkg::OP_W-1:0]   out_opcode,
  input  logic                        out_undefined_encoding,
  input  logic                        out_permitted,
  input  logic [2:0]                  out_reg_first,
  input  logic [2:0]                  out_reg_second,
  input  logic [2:0]                  out_reg_third,
  input  logic [3:0]                  out_shift_count,
  input  logic [8:0]                  out_imm_or_address,
  input  logic [3:0]                  out_cond_or_mask,
  input  logic signed [7:0]           out_jump_offset,
  input  logic [4:0]                  out_jump_base,
  input  logic [2:0]                  out_port_number,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [r16d_pkg::MASK_W-1:0] cfg_opcode_enable_mask,
  output int                          mismatch_count,
  output int                          pending_count
);

  localparam int          PRINT_LIMIT = 50;
  localparam logic [2:0]  MEM_CLASS   = 3'b111;
  localparam logic [2:0]  MEM_LAST    = 3'd5;
  localparam logic [1:0]  LO_RESERVED = 2'b11;

  typedef enum logic [1:0] {JF_ABS, JF_REL, JF_EQ, JF_ALL} jump_form_e;
  typedef enum logic [2:0] {
    RG_MOVE, RG_ALU1, RG_LOGIC, RG_ALU3, RG_SHIFT, RG_BSH, RG_XCH, RG_TST_CMP
  } reg_group_e;

  logic [r16d_pkg::MASK_W-1:0] enable_mask;
  r16d_pkg::dec_t              pending_decodes[$];
  int                          result_index;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    result_index   = 0;
  end

  function automatic r16d_pkg::dec_t decode_instruction(
      input logic [r16d_pkg::WORD_W-1:0] w,
      input logic [r16d_pkg::MASK_W-1:0] mask);
    r16d_pkg::dec_t d;
    logic defined;
    logic [1:0] lo;
    d = '0;
    defined = 1'b1;
    lo = w[1:0];
    if (w[15]) begin
      if (w[14:12] != MEM_CLASS) begin
        d.opcode = r16d_pkg::IMM_OPS[w[14:12]];
        d.reg_first = w[11:9];
        d.imm_or_address = w[8:0];
      end else if (w[11:9] > MEM_LAST) begin
        defined = 1'b0;
      end else begin
        d.opcode = r16d_pkg::MEM_OPS[w[11:9]];
        d.reg_first = w[7:5];
        d.reg_second = w[4:2];
      end
    end else if (w[14]) begin
      if (w[13]) begin
        d.opcode = r16d_pkg::OP_IO_B + {4'd0, w[12:11]};
        d.reg_first = w[10:8];
        d.port_number = w[7:5];
      end else begin
        case (jump_form_e'(w[12:11]))
          JF_ABS: begin
            d.opcode = r16d_pkg::OP_JC;
            d.cond_or_mask = {1'b0, w[10:8]};
            d.jump_offset = w[7:0];
          end
          JF_REL: begin
            d.opcode = r16d_pkg::OP_JRELC;
            d.cond_or_mask = {1'b0, w[10:8]};
            d.reg_second = w[7:5];
            d.jump_base = w[4:0];
          end
          default: begin
            d.opcode = ((jump_form_e'(w[12:11]) == JF_EQ) ? r16d_pkg::OP_JEC
                                                           : r16d_pkg::OP_JAC)
                       + {5'd0, !w[6]};
            d.cond_or_mask = w[10:7];
            d.jump_offset = {{2{w[5]}}, w[5:0]};
          end
        endcase
      end
    end else begin
      case (reg_group_e'(w[13:11]))
        RG_MOVE, RG_ALU1: begin
          if (lo == LO_RESERVED) begin
            defined = 1'b0;
          end else begin
            d.opcode = ((reg_group_e'(w[13:11]) == RG_MOVE) ? r16d_pkg::OP_MOV
                                                             : r16d_pkg::OP_ALU1_B)
                       + {4'd0, lo};
            d.reg_first = w[10:8];
            d.reg_second = w[7:5];
            // plain move carries no third register
            if (d.opcode != r16d_pkg::OP_MOV) d.reg_third = w[4:2];
          end
        end
        RG_LOGIC, RG_ALU3: begin
          if (reg_group_e'(w[13:11]) == RG_LOGIC)
            d.opcode = w[0] ? r16d_pkg::OP_OR : r16d_pkg::OP_AND;
          else d.opcode = r16d_pkg::OP_ALU3_B + {4'd0, lo};
          d.reg_first = w[10:8];
          d.reg_second = w[7:5];
          d.reg_third = w[4:2];
        end
        RG_SHIFT: begin
          d.opcode = w[4] ? r16d_pkg::OP_SHR : r16d_pkg::OP_SHL;
          d.reg_first = w[10:8];
          d.reg_second = w[7:5];
          d.shift_count = w[3:0];
        end
        RG_BSH: begin
          d.opcode = w[0] ? r16d_pkg::OP_ABSH : r16d_pkg::OP_BSH;
          d.reg_first = w[10:8];
          d.reg_second = w[7:5];
          d.shift_count = {1'b0, w[4:2]};
        end
        RG_XCH: begin
          d.opcode = r16d_pkg::OP_XCH;
          d.reg_first = w[7:5];
          d.reg_second = w[4:2];
        end
        default: begin
          d.opcode = w[0] ? r16d_pkg::OP_CMP : r16d_pkg::OP_TST;
          d.reg_first = w[7:5];
          if (w[0]) d.reg_second = w[4:2];
        end
      endcase
    end
    if (!defined) begin
      d = '0;
      d.undefined_encoding = 1'b1;
    end else begin
      d.permitted = mask[d.opcode];
    end
    return d;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatch_count < PRINT_LIMIT)
      $display("decode item %0d: %s is %0d, predicted %0d", result_index, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    r16d_pkg::dec_t got;
    r16d_pkg::dec_t want;
    if (!rst_n) begin
      pending_decodes.delete();
      enable_mask = r16d_pkg::MASK_RESET;
    end else begin
      if (in_valid && in_ready)
        pending_decodes.push_back(decode_instruction(in_instruction_word, enable_mask));
      if (out_valid && out_ready) begin
        got = '{out_opcode, out_undefined_encoding, out_permitted, out_reg_first,
                out_reg_second, out_reg_third, out_shift_count, out_imm_or_address,
                out_cond_or_mask, out_jump_offset, out_jump_base, out_port_number};
        if (pending_decodes.size() == 0) begin
          report_mismatch("unpredicted item, opcode", got.opcode, -1);
        end else begin
          want = pending_decodes.pop_front();
          if (got.opcode !== want.opcode)
            report_mismatch("opcode", got.opcode, want.opcode);
          if (got.undefined_encoding !== want.undefined_encoding)
            report_mismatch("undefined_encoding", got.undefined_encoding,
                            want.undefined_encoding);
          if (got.permitted !== want.permitted)
            report_mismatch("permitted", got.permitted, want.permitted);
          if (got.reg_first !== want.reg_first)
            report_mismatch("reg_first", got.reg_first, want.reg_first);
          if (got.reg_second !== want.reg_second)
            report_mismatch("reg_second", got.reg_second, want.reg_second);
          if (got.reg_third !== want.reg_third)
            report_mismatch("reg_third", got.reg_third, want.reg_third);
          if (got.shift_count !== want.shift_count)
            report_mismatch("shift_count", got.shift_count, want.shift_count);
          if (got.imm_or_address !== want.imm_or_address)
            report_mismatch("imm_or_address", got.imm_or_address, want.imm_or_address);
          if (got.cond_or_mask !== want.cond_or_mask)
            report_mismatch("cond_or_mask", got.cond_or_mask, want.cond_or_mask);
          if (got.jump_offset !== want.jump_offset)
            report_mismatch("jump_offset", int'(got.jump_offset), int'(want.jump_offset));
          if (got.jump_base !== want.jump_base)
            report_mismatch("jump_base", got.jump_base, want.jump_base);
          if (got.port_number !== want.port_number)
            report_mismatch("port_number", got.port_number, want.port_number);
        end
        result_index++;
      end
      if (cfg_valid && cfg_ready) enable_mask = cfg_opcode_enable_mask;
    end
    pending_count <= pending_decodes.size();
  end

endmodule

@@ bench/testbench.sv @@
module testbench;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 9;
  localparam int LIMIT_CYCLES   = 300000;
  localparam int SQUEEZE_CYCLES = 60;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_ITEMS    = 140;
  localparam int SQUEEZE_ITEMS  = 40;

  // hand-picked words: field extremes, every undefined shape, each jump form,
  // both signs of the short jump offset, the io group and register groups 0, 1, 3, 4, 5 and 7
  localparam logic [r16d_pkg::WORD_W-1:0] CORNER_WORDS [25] = '{
    16'h0000, 16'hFFFF, 16'h0003, 16'h0803, 16'hFC00,
    16'hFDFF, 16'h8000, 16'hEFFF, 16'hF000, 16'hFBFF,
    16'h4080, 16'h407F, 16'h4FFF, 16'h5060, 16'h501F,
    16'h5FFF, 16'h5800, 16'h6000, 16'h7FFF, 16'h0002,
    16'h1FFF, 16'h2FFF, 16'h27FF, 16'h3FFE, 16'h3FFF
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [r16d_pkg::WORD_W-1:0]   in_instruction_word = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [r16d_pkg::OP_W-1:0]     out_opcode;
  logic                          out_undefined_encoding;
  logic                          out_permitted;
  logic [2:0]                    out_reg_first;
  logic [2:0]                    out_reg_second;
  logic [2:0]                    out_reg_third;
  logic [3:0]                    out_shift_count;
  logic [8:0]                    out_imm_or_address;
  logic [3:0]                    out_cond_or_mask;
  logic signed [7:0]             out_jump_offset;
  logic [4:0]                    out_jump_base;
  logic [2:0]                    out_port_number;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [r16d_pkg::MASK_W-1:0]   cfg_opcode_enable_mask = '0;

  int mismatch_count;
  int pending_count;

  // pacing knobs set by the stimulus and read by the word feeder and the result drain
  bit tx_steady = 1'b1;
  bit rx_steady = 1'b1;
  int squeeze_asked = 0;
  int squeeze_given = 0;

  always #HALF_PERIOD clk = ~clk;

  risc16_instruction_decoder_unit dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_instruction_word    (in_instruction_word),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_opcode             (out_opcode),
    .out_undefined_encoding (out_undefined_encoding),
    .out_permitted          (out_permitted),
    .out_reg_first          (out_reg_first),
    .out_reg_second         (out_reg_second),
    .out_reg_third          (out_reg_third),
    .out_shift_count        (out_shift_count),
    .out_imm_or_address     (out_imm_or_address),
    .out_cond_or_mask       (out_cond_or_mask),
    .out_jump_offset        (out_jump_offset),
    .out_jump_base          (out_jump_base),
    .out_port_number        (out_port_number),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_opcode_enable_mask (cfg_opcode_enable_mask)
  );

  // checker sits beside the block and watches all three channels
  r16d_decode_checker decode_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_instruction_word    (in_instruction_word),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_opcode             (out_opcode),
    .out_undefined_encoding (out_undefined_encoding),
    .out_permitted          (out_permitted),
    .out_reg_first          (out_reg_first),
    .out_reg_second         (out_reg_second),
    .out_reg_third          (out_reg_third),
    .out_shift_count        (out_shift_count),
    .out_imm_or_address     (out_imm_or_address),
    .out_cond_or_mask       (out_cond_or_mask),
    .out_jump_offset        (out_jump_offset),
    .out_jump_base          (out_jump_base),
    .out_port_number        (out_port_number),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_opcode_enable_mask (cfg_opcode_enable_mask),
    .mismatch_count         (mismatch_count),
    .pending_count          (pending_count)
  );

  // mostly short pauses, now and then a long one
  function automatic int random_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // any word is legal input, so random words already reach every form;
  // some get their low operand bits pinned to all ones or all zeros
  function automatic logic [r16d_pkg::WORD_W-1:0] random_word();
    logic [31:0]                 r;
    logic [r16d_pkg::WORD_W-1:0] w;
    r = $urandom;
    w = r[r16d_pkg::WORD_W-1:0];
    case ($urandom_range(0, 9))
      0: w[8:0] = '1;
      1: w[8:0] = '0;
      2: w[5:0] = '1;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [r16d_pkg::MASK_W-1:0] random_mask();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[r16d_pkg::MASK_W-1:0];
  endfunction

  // offer one item and hold it until the block takes it; valid stays high
  // into the next item when there is no gap
  task automatic send_word(input logic [r16d_pkg::WORD_W-1:0] w);
    int gap;
    gap = (!tx_steady && $urandom_range(0, 99) < 40) ? random_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_instruction_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_word(random_word());
  endtask

  // stop feeding and wait for every outstanding item to drain
  task automatic drain_pipe();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // the enable mask only changes while nothing is in flight
  task automatic write_enable_mask(input logic [r16d_pkg::MASK_W-1:0] m);
    drain_pipe();
    cfg_valid <= 1'b1;
    cfg_opcode_enable_mask <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result drain: random back-pressure, plus one long hold on request so the
  // two pipeline registers fill and in_ready has to drop
  initial begin : result_drain
    int idle_left;
    idle_left = 0;
    forever begin
      @(posedge clk);
      if (squeeze_asked > squeeze_given) begin
        squeeze_given++;
        out_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else if (idle_left > 0) begin
        idle_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 99) < 30) idle_left = random_gap();
      end
    end
  end

  // run limit
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // corner words back to back under the reset mask
    foreach (CORNER_WORDS[i]) send_word(CORNER_WORDS[i]);

    // reset mask, both sides pausing
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    send_random(PHASE_ITEMS);

    // everything enabled; start with a long output stall against a full-rate feed
    write_enable_mask({r16d_pkg::MASK_W{1'b1}});
    tx_steady = 1'b1;
    squeeze_asked++;
    send_random(SQUEEZE_ITEMS);
    tx_steady = 1'b0;
    send_random(PHASE_ITEMS);

    // nothing enabled, drain always ready
    write_enable_mask('0);
    rx_steady = 1'b1;
    send_random(PHASE_ITEMS);

    // random mask, full-rate feed against a stalling drain
    write_enable_mask(random_mask());
    tx_steady = 1'b1;
    rx_steady = 1'b0;
    send_random(PHASE_ITEMS);

    // alternating enable bits, both sides pausing
    write_enable_mask(42'h2AAAAAAAAAA);
    tx_steady = 1'b0;
    send_random(PHASE_ITEMS);

    drain_pipe();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/r16d_pkg.sv
design/r16d_mask_reg.sv
design/r16d_decode.sv
design/risc16_instruction_decoder_unit.sv
design/r16d_checker.sv
bench/r16d_decode_checker.sv
bench/testbench.sv
